// File: rtl/rcf_pkg.sv
`default_nettype none

package rcf_pkg;

	// Line geometry.
	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int COL_W     = 11;
	localparam int ROW_W     = 16;
	localparam int WIDTH_W   = 12;

	// Fixed-point formats.
	localparam int COEF_FRAC_BITS = 12;
	localparam int TAP_W    = 16;
	localparam int PIX_W    = 8;
	localparam int PROD_W   = PIX_W + TAP_W;
	localparam int ROWSUM_W = PROD_W + 2;
	localparam int SUM_W    = ROWSUM_W + 2;
	localparam int NUM_TAPS = 9;
	localparam int NUM_CH   = 4;

	// Configuration port.
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

	localparam logic [CFG_W-1:0]   COEF_RESET   = 48'h01C7_01C7_01C7;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;

	typedef struct packed {
		logic [PIX_W-1:0] alpha;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	// Both line stores share one word: upper row in the high half.
	typedef struct packed {
		pixel_t upper;
		pixel_t lower;
	} line_word_t;

	typedef logic [NUM_TAPS-1:0][PIX_W-1:0] pix9_t;
	typedef logic [NUM_TAPS-1:0][TAP_W-1:0] tap9_t;

	// Sideband that travels with an item down the pipeline.
	typedef struct packed {
		logic             res;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             last;
	} side_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] alpha;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             last;
	} result_t;

	// Tap at position 0 (left), 1 (center) or 2 (right) of a kernel row.
	function automatic logic [TAP_W-1:0] tap_of(input logic [CFG_W-1:0] coef_row,
			input int pos);
		logic [TAP_W-1:0] t;
		case (pos)
			0: t = coef_row[TAP_W-1:0];
			1: t = coef_row[2*TAP_W-1:TAP_W];
			default: t = coef_row[3*TAP_W-1:2*TAP_W];
		endcase
		return t;
	endfunction

	// Drop the fraction (toward zero for positive sums) and clamp to 0..255.
	function automatic logic [PIX_W-1:0] finish(input logic signed [SUM_W-1:0] sum);
		logic [SUM_W-COEF_FRAC_BITS-1:0] q;
		logic [PIX_W-1:0] r;
		q = sum[SUM_W-1:COEF_FRAC_BITS];
		if (sum <= 0) begin
			r = '0;
		end else if (q > (SUM_W-COEF_FRAC_BITS)'(2**PIX_W - 1)) begin
			r = '1;
		end else begin
			r = q[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rgba_conv3x3_filter.sv
// Streaming 3x3 convolution of RGBA pixels.
//
// Pixels enter on the input channel (in_valid/in_ready) in raster order, one
// item per pixel. Results leave on the output channel (out_valid/out_ready),
// one item for each interior pixel; border pixels are consumed silently.
// frame_last marks the result for the last interior pixel of the frame.
// The kernel rows and the image geometry are set through the write port
// (cfg_wr_en, cfg_index, cfg_data); the user must write them only while the
// block is idle, which the block itself does not enforce. Writing the width
// or height restarts the frame at column zero, row zero.
// The block takes one item per clock while in_ready is high. An accepted
// pixel passes through the line memory read, the window register, the
// product, row sum and total sum registers of each channel lane, and the
// output register. The line memory holds both previous rows in one word
// and needs no clearing pass; a row is always written before it is read.
//
// Reset clears the counters, the window and all valid flags, and restores
// the default kernel (each tap about 1/9) and a 640 by 480 frame. When the
// receiver stalls, a skid register takes one more result; only when that is
// full does in_ready drop, and the whole pipeline holds until it drains.

`default_nettype none

module rgba_conv3x3_filter (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire  [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [rcf_pkg::CFG_W-1:0]     cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [7:0]                    red_in,
	input  wire  [7:0]                    green_in,
	input  wire  [7:0]                    blue_in,
	input  wire  [7:0]                    alpha_in,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [7:0]                    red_out,
	output logic [7:0]                    green_out,
	output logic [7:0]                    blue_out,
	output logic [7:0]                    alpha_out,
	output logic [10:0]                   out_column,
	output logic [15:0]                   out_row,
	output logic                          frame_last
);
	import rcf_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0]   coef_top_q;
	logic [CFG_W-1:0]   coef_mid_q;
	logic [CFG_W-1:0]   coef_bot_q;
	logic [WIDTH_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;

	// Position of the next incoming pixel.
	logic [ADDR_W-1:0] col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] width_last;
	logic [ROW_W-1:0]  height_last;

	logic en;
	logic accept;

	// Stage 1: pixel and line memory data.
	logic              item_s1;
	pixel_t            pix_s1;
	logic [ADDR_W-1:0] idx_s1;
	line_word_t        rd_word;
	side_t             side_s0;
	side_t             side_s1, side_s2, side_s3, side_s4, side_s5;

	// 3x3 window: two stored columns plus the fresh column.
	pixel_t win_left_q [3];
	pixel_t win_mid_q  [3];
	pixel_t fresh [3];

	pix9_t  grid_ch [NUM_CH];
	pix9_t  pix_s2  [NUM_CH];
	tap9_t  taps;
	logic [PIX_W-1:0] lane_res [NUM_CH];

	result_t merged;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    new_valid;

	// Effective geometry: width clamped to 3..MAX_WIDTH, height to at least 3.
	always_comb begin
		if (width_q < WIDTH_W'(3)) begin
			width_last = ADDR_W'(2);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			width_last = ADDR_W'(MAX_WIDTH - 1);
		end else begin
			width_last = ADDR_W'(width_q - WIDTH_W'(1));
		end
		if (height_q < ROW_W'(3)) begin
			height_last = ROW_W'(2);
		end else begin
			height_last = height_q - ROW_W'(1);
		end
	end

	// The pipeline holds only while the skid register is occupied.
	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign accept   = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= COEF_RESET;
			coef_mid_q <= COEF_RESET;
			coef_bot_q <= COEF_RESET;
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COEF_TOP:     coef_top_q <= cfg_data;
				REG_COEF_MIDDLE:  coef_mid_q <= cfg_data;
				REG_COEF_BOTTOM:  coef_bot_q <= cfg_data;
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Raster counters; a geometry write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH
				|| cfg_index == REG_IMAGE_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == width_last) begin
				col_q <= '0;
				row_q <= (row_q == height_last) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + ADDR_W'(1);
			end
		end
	end

	// A result exists once two full rows and two columns are behind us.
	always_comb begin
		side_s0.res    = accept && (row_q >= ROW_W'(2)) && (col_q >= ADDR_W'(2));
		side_s0.column = COL_W'(col_q - ADDR_W'(1));
		side_s0.row    = row_q - ROW_W'(1);
		side_s0.last   = (row_q == height_last) && (col_q == width_last);
	end

	rcf_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (en),
		.rd_addr (col_q),
		.rd_data (rd_word),
		.wr_en   (en && item_s1),
		.wr_addr (idx_s1),
		.wr_data ({rd_word.lower, pix_s1})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= 1'b0;
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (en) begin
			item_s1 <= accept;
			side_s1 <= side_s0;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= {alpha_in, blue_in, green_in, red_in};
			idx_s1 <= col_q;
		end
	end

	// Column of the newest pixel: two rows above, one row above, current row.
	always_comb begin
		fresh[0] = rd_word.upper;
		fresh[1] = rd_word.lower;
		fresh[2] = pix_s1;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int r = 0; r < 3; r++) begin
				grid_ch[ch][3*r]   = win_left_q[r][PIX_W*ch +: PIX_W];
				grid_ch[ch][3*r+1] = win_mid_q[r][PIX_W*ch +: PIX_W];
				grid_ch[ch][3*r+2] = fresh[r][PIX_W*ch +: PIX_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_left_q[r] <= '0;
				win_mid_q[r]  <= '0;
			end
		end else if (en && item_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_left_q[r] <= win_mid_q[r];
				win_mid_q[r]  <= fresh[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				pix_s2[ch] <= grid_ch[ch];
			end
		end
	end

	// Kernel taps, in the same row-major order as the window.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			taps[c]   = tap_of(coef_top_q, c);
			taps[3+c] = tap_of(coef_mid_q, c);
			taps[6+c] = tap_of(coef_bot_q, c);
		end
	end

	// One lane per color channel.
	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		rcf_lane u_lane (
			.clk    (clk),
			.en     (en),
			.pix_s2 (pix_s2[ch]),
			.taps   (taps),
			.result (lane_res[ch])
		);
	end

	// Merge the four lanes with the position sideband.
	always_comb begin
		merged.red    = lane_res[0];
		merged.green  = lane_res[1];
		merged.blue   = lane_res[2];
		merged.alpha  = lane_res[3];
		merged.column = side_s5.column;
		merged.row    = side_s5.row;
		merged.last   = side_s5.last;
	end

	assign new_valid = en && side_s5.res;

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= new_valid;
		end else if (new_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_ready) begin
			if (new_valid) begin
				out_q <= merged;
			end
		end else if (new_valid) begin
			skid_q <= merged;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = out_q.red;
	assign green_out  = out_q.green;
	assign blue_out   = out_q.blue;
	assign alpha_out  = out_q.alpha;
	assign out_column = out_q.column;
	assign out_row    = out_q.row;
	assign frame_last = out_q.last;

endmodule

`default_nettype wire

// File: rtl/rcf_line_mem.sv
`default_nettype none

module rcf_line_mem (
	input  wire                       clk,
	input  wire                       rd_en,
	input  wire  [rcf_pkg::ADDR_W-1:0] rd_addr,
	output rcf_pkg::line_word_t       rd_data,
	input  wire                       wr_en,
	input  wire  [rcf_pkg::ADDR_W-1:0] wr_addr,
	input  rcf_pkg::line_word_t       wr_data
);
	import rcf_pkg::*;

	line_word_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/rcf_lane.sv
`default_nettype none

module rcf_lane (
	input  wire                       clk,
	input  wire                       en,
	input  rcf_pkg::pix9_t            pix_s2,
	input  rcf_pkg::tap9_t            taps,
	output logic [rcf_pkg::PIX_W-1:0] result
);
	import rcf_pkg::*;

	logic signed [PROD_W-1:0]   mul [NUM_TAPS];
	logic signed [PROD_W-1:0]   prod_s3 [NUM_TAPS];
	logic signed [ROWSUM_W-1:0] rowsum_s4 [3];
	logic signed [SUM_W-1:0]    sum_s5;

	// Nine independent multipliers, pixel unsigned times tap signed.
	// The largest product, 255 times -32768, still fits in PROD_W bits.
	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			mul[i] = $signed({1'b0, pix_s2[i]}) * $signed(taps[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				prod_s3[i] <= mul[i];
			end
			for (int r = 0; r < 3; r++) begin
				rowsum_s4[r] <= ROWSUM_W'(prod_s3[3*r]) + ROWSUM_W'(prod_s3[3*r+1])
					+ ROWSUM_W'(prod_s3[3*r+2]);
			end
			sum_s5 <= SUM_W'(rowsum_s4[0]) + SUM_W'(rowsum_s4[1]) + SUM_W'(rowsum_s4[2]);
		end
	end

	assign result = finish(sum_s5);

endmodule

`default_nettype wire

// File: rtl/rcf_checker.sv
`default_nettype none

module rcf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [7:0]  red_out,
	input wire [7:0]  green_out,
	input wire [7:0]  blue_out,
	input wire [7:0]  alpha_out,
	input wire [10:0] out_column,
	input wire [15:0] out_row,
	input wire        frame_last
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({red_out, green_out, blue_out, alpha_out,
				out_column, out_row, frame_last}))
		else $error("stalled result changed");

	// Input back-pressure only happens while a result is waiting.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// Results are interior pixels only.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_column != 11'd0 && out_row != 16'd0)
		else $error("result on a border pixel");

	// Once reset has been seen at an edge, the output is empty at the next one.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid && in_ready)
		else $error("output not empty during reset");

endmodule

bind rgba_conv3x3_filter rcf_checker u_rcf_checker (.*);

`default_nettype wire
